/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Property check helpers for concurrent assertions. They are empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// lbl: name of the check, clk/rst_n: its clock and active low reset
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("property check failed");
// a on one edge implies c on the next edge
`define ASSERT_NEXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("next-cycle check failed");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEXT(lbl, clk, rst_n, a, c)
`endif

`endif

/* hw/rtl/ebbs_pkg.sv */
// ----------------------------------------------------------------------------
// ebbs_pkg
// Types, constants and fixed-point helpers of the bouncing body stepper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ebbs_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int COUNT_WIDTH = 16;
  localparam int Q_W         = 32;
  localparam int DT_W        = 31;
  localparam int IDX_W       = 3;
  localparam int PROD_W      = 2 * Q_W;
  localparam int RND_W       = PROD_W - FRAC_BITS;

  localparam longint ONE_Q = longint'(1) << FRAC_BITS;

  localparam logic signed [Q_W-1:0] GRAV_Q   = Q_W'(-((98 * ONE_Q + 5) / 10));
  localparam logic signed [Q_W-1:0] BOUNCE_Q = Q_W'((8 * ONE_Q + 5) / 10);
  localparam logic signed [Q_W-1:0] LIFT_Q   = Q_W'((ONE_Q + 50) / 100);
  localparam logic signed [PROD_W-1:0] HALF_Q = PROD_W'(ONE_Q / 2);

  localparam logic signed [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
  localparam logic signed [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

  localparam logic [DT_W-1:0]        DT_RESET    = DT_W'(6554);
  localparam logic [COUNT_WIDTH-1:0] LIMIT_RESET = COUNT_WIDTH'(300);

  typedef enum logic [IDX_W-1:0] {
    REG_INIT_POS_X = 3'd0,
    REG_INIT_POS_Y = 3'd1,
    REG_INIT_POS_Z = 3'd2,
    REG_INIT_VEL_X = 3'd3,
    REG_INIT_VEL_Y = 3'd4,
    REG_INIT_VEL_Z = 3'd5,
    REG_TIME_STEP  = 3'd6,
    REG_STEP_LIMIT = 3'd7
  } reg_idx_e;

  // multiplier jobs
  typedef enum logic [2:0] {
    OP_X = 3'd0,  // vx * dt
    OP_Y = 3'd1,  // vy * dt
    OP_Z = 3'd2,  // vz_prev * dt
    OP_G = 3'd3,  // g * dt
    OP_B = 3'd4   // vz_new * bounce
  } mul_op_e;

  typedef struct packed {
    logic    load;     // prev state <- initial registers
    logic    finish;   // end run, show initial position
    logic    set_run;
    logic    issue;    // start a multiply
    mul_op_e op;
    logic    commit;   // take the step results
    logic    emit;     // load the output register
  } ebbs_cmd_t;

  typedef struct packed {
    logic running;
    logic count_ge;   // step count has reached the limit
    logic z_neg;      // new z went below the floor
    logic out_free;
  } ebbs_sts_t;

  // saturate a 33-bit sum to Q range
  function automatic logic signed [Q_W-1:0] sat_sum(input logic signed [Q_W:0] s);
    if (s[Q_W] == s[Q_W-1]) begin
      return s[Q_W-1:0];
    end
    return s[Q_W] ? Q_MIN : Q_MAX;
  endfunction

  // round product to nearest (ties away from zero) and saturate
  function automatic logic signed [Q_W-1:0] round_sat(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] sum;
    logic signed [RND_W-1:0]  r;
    sum = p + (p[PROD_W-1] ? HALF_Q - PROD_W'(1) : HALF_Q);
    r   = sum[PROD_W-1:FRAC_BITS];
    if (r[RND_W-1:Q_W-1] == {(RND_W-Q_W+1){r[RND_W-1]}}) begin
      return r[Q_W-1:0];
    end
    return r[RND_W-1] ? Q_MIN : Q_MAX;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/ebbs_if.sv */
// ----------------------------------------------------------------------------
// ebbs channel interfaces
// Valid/ready channels for ticks, results and register writes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ebbs_in_if;
  logic valid;
  logic ready;
  logic start_request;

  modport source (output valid, output start_request, input ready);
  modport sink   (input valid, input start_request, output ready);
endinterface

interface ebbs_out_if import ebbs_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [Q_W-1:0]         pos_x;
  logic signed [Q_W-1:0]         pos_y;
  logic signed [Q_W-1:0]         pos_z;
  logic signed [Q_W-1:0]         vel_z;
  logic                          is_running;
  logic        [COUNT_WIDTH-1:0] steps_done;

  modport source (output valid, output pos_x, output pos_y, output pos_z, output vel_z,
                  output is_running, output steps_done, input ready);
  modport sink   (input valid, input pos_x, input pos_y, input pos_z, input vel_z,
                  input is_running, input steps_done, output ready);
endinterface

interface ebbs_cfg_if import ebbs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] index;
  logic [Q_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/euler_bouncing_body_stepper_core.sv */
// ----------------------------------------------------------------------------
// euler_bouncing_body_stepper_core
// Explicit Euler point-mass stepper with a bouncing floor, at most one step per tick.
// ----------------------------------------------------------------------------
// Usage:
//   in_i  : one beat per simulation tick, carrying start_request. A request
//           while idle loads the initial position and z velocity and starts a
//           run; requests during a run are ignored.
//   out_o : exactly one result beat per tick: shown position, z velocity,
//           running flag and step count after that tick.
//   cfg_i : register writes (index 0..7, init pos x/y/z, init vel x/y/z,
//           time step, step limit), always ready, applied on the beat. Write
//           only while no tick is in flight.
// Schedule:
//   A running tick issues four products per step back to back through the
//   one shared 32x32 multiplier, a three-stage multiply/round/accumulate
//   pipe, plus an extra bounce multiply when the body hits the floor.
//   Ticks that do not step (idle, or the run ending) skip the multiplier.
//   One tick is in flight at a time.
// Reset: run idle, step count and positions zero, dt = 0.1, limit = 300.
// Stall: the result sits in the output register; the next tick is accepted
//   meanwhile, but its result waits until the held beat is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module euler_bouncing_body_stepper_core import ebbs_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ebbs_in_if.sink   in_i,
  ebbs_cfg_if.sink  cfg_i,
  ebbs_out_if.source out_o
);

  ebbs_cmd_t cmd;
  ebbs_sts_t sts;

  // register writes never stall
  assign cfg_i.ready = 1'b1;

  // sequencer: owns the tick decision and the multiplier schedule
  ebbs_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_i.valid),
    .start_request_i (in_i.start_request),
    .in_ready_o      (in_i.ready),
    .sts_i           (sts),
    .cmd_o           (cmd)
  );

  // datapath: registers, run state, multiply pipe, result register
  ebbs_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_i.valid),
    .cfg_index_i  (cfg_i.index),
    .cfg_data_i   (cfg_i.data),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_ready_i  (out_o.ready),
    .out_valid_o  (out_o.valid),
    .pos_x_o      (out_o.pos_x),
    .pos_y_o      (out_o.pos_y),
    .pos_z_o      (out_o.pos_z),
    .vel_z_o      (out_o.vel_z),
    .is_running_o (out_o.is_running),
    .steps_done_o (out_o.steps_done)
  );

endmodule

`default_nettype wire

/* hw/rtl/ebbs_ctrl.sv */
// ----------------------------------------------------------------------------
// ebbs_ctrl
// Tick sequencer: decides the tick, schedules the shared multiplier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module ebbs_ctrl import ebbs_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  input  wire logic      start_request_i,
  output logic           in_ready_o,
  input  wire ebbs_sts_t sts_i,
  output ebbs_cmd_t      cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_X, S_Y, S_Z, S_G, S_D1, S_D2, S_CHK, S_B1, S_B2, S_COMMIT, S_EMIT
  } state_e;

  state_e state_q, state_d;
  logic   start;

  assign in_ready_o = (state_q == S_IDLE);
  assign start      = !sts_i.running && start_request_i;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load    = start;
          cmd_o.finish  = sts_i.count_ge;
          cmd_o.set_run = start && !sts_i.count_ge;
          if (!sts_i.count_ge && (sts_i.running || start)) begin
            state_d = S_X;
          end else begin
            state_d = S_EMIT;
          end
        end
      end
      S_X: begin
        cmd_o.issue = 1'b1;
        cmd_o.op    = OP_X;
        state_d     = S_Y;
      end
      S_Y: begin
        cmd_o.issue = 1'b1;
        cmd_o.op    = OP_Y;
        state_d     = S_Z;
      end
      S_Z: begin
        cmd_o.issue = 1'b1;
        cmd_o.op    = OP_Z;
        state_d     = S_G;
      end
      S_G: begin
        cmd_o.issue = 1'b1;
        cmd_o.op    = OP_G;
        state_d     = S_D1;
      end
      S_D1: state_d = S_D2;
      S_D2: state_d = S_CHK;
      S_CHK: begin
        if (sts_i.z_neg) begin
          cmd_o.issue = 1'b1;
          cmd_o.op    = OP_B;
          state_d     = S_B1;
        end else begin
          cmd_o.commit = 1'b1;
          state_d      = S_EMIT;
        end
      end
      S_B1: state_d = S_B2;
      S_B2: state_d = S_COMMIT;
      S_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = S_EMIT;
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `ASSERT_PROP(a_bounce_only_below, clk_i, rst_ni, (cmd_o.issue && cmd_o.op == OP_B) |-> sts_i.z_neg)
  `ASSERT_PROP(a_emit_needs_room, clk_i, rst_ni, cmd_o.emit |-> sts_i.out_free)
  `ASSERT_PROP(a_commit_in_run, clk_i, rst_ni, cmd_o.commit |-> sts_i.running)
  `ASSERT_NEXT(a_beat_leaves_idle, clk_i, rst_ni, in_valid_i && in_ready_o, state_q != S_IDLE)

endmodule

`default_nettype wire

/* hw/rtl/ebbs_dp.sv */
// ----------------------------------------------------------------------------
// ebbs_dp
// Registers, run state, shared multiplier pipe and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ebbs_dp import ebbs_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_we_i,
  input  wire logic [IDX_W-1:0]        cfg_index_i,
  input  wire logic [Q_W-1:0]          cfg_data_i,
  input  wire ebbs_cmd_t               cmd_i,
  output ebbs_sts_t                    sts_o,
  input  wire logic                    out_ready_i,
  output logic                         out_valid_o,
  output logic signed [Q_W-1:0]        pos_x_o,
  output logic signed [Q_W-1:0]        pos_y_o,
  output logic signed [Q_W-1:0]        pos_z_o,
  output logic signed [Q_W-1:0]        vel_z_o,
  output logic                         is_running_o,
  output logic        [COUNT_WIDTH-1:0] steps_done_o
);

  // config registers
  logic signed [Q_W-1:0]         ipx_q, ipy_q, ipz_q, ivx_q, ivy_q, ivz_q;
  logic        [DT_W-1:0]        dt_q;
  logic        [COUNT_WIDTH-1:0] limit_q;

  // run state
  logic                          run_q;
  logic        [COUNT_WIDTH-1:0] count_q;
  logic signed [Q_W-1:0]         px_q, py_q, pz_q, pvz_q;
  logic signed [Q_W-1:0]         sx_q, sy_q, sz_q;

  // step results
  logic signed [Q_W-1:0]         nx_q, ny_q, nz_q, nvz_q;
  logic signed [Q_W-1:0]         nz_lift;

  // multiplier pipe
  logic signed [Q_W-1:0]         mul_a, mul_b;
  logic signed [PROD_W-1:0]      prod_q;
  logic                          s1_vld_q, s2_vld_q;
  mul_op_e                       s1_op_q, s2_op_q;
  logic signed [Q_W-1:0]         rnd_q;

  logic                          out_vld_q;
  logic                          out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ipx_q   <= '0;
      ipy_q   <= '0;
      ipz_q   <= '0;
      ivx_q   <= '0;
      ivy_q   <= '0;
      ivz_q   <= '0;
      dt_q    <= DT_RESET;
      limit_q <= LIMIT_RESET;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_INIT_POS_X: ipx_q   <= cfg_data_i;
        REG_INIT_POS_Y: ipy_q   <= cfg_data_i;
        REG_INIT_POS_Z: ipz_q   <= cfg_data_i;
        REG_INIT_VEL_X: ivx_q   <= cfg_data_i;
        REG_INIT_VEL_Y: ivy_q   <= cfg_data_i;
        REG_INIT_VEL_Z: ivz_q   <= cfg_data_i;
        REG_TIME_STEP:  dt_q    <= cfg_data_i[DT_W-1:0];
        REG_STEP_LIMIT: limit_q <= cfg_data_i[COUNT_WIDTH-1:0];
        default:        dt_q    <= dt_q;
      endcase
    end
  end

  assign nz_lift = nz_q[Q_W-1] ? LIFT_Q : nz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q   <= 1'b0;
      count_q <= '0;
      px_q    <= '0;
      py_q    <= '0;
      pz_q    <= '0;
      pvz_q   <= '0;
      sx_q    <= '0;
      sy_q    <= '0;
      sz_q    <= '0;
    end else begin
      if (cmd_i.load) begin
        px_q  <= ipx_q;
        py_q  <= ipy_q;
        pz_q  <= ipz_q;
        pvz_q <= ivz_q;
      end
      if (cmd_i.set_run) begin
        run_q <= 1'b1;
      end
      if (cmd_i.finish) begin
        run_q   <= 1'b0;
        count_q <= '0;
        sx_q    <= ipx_q;
        sy_q    <= ipy_q;
        sz_q    <= ipz_q;
      end
      if (cmd_i.commit) begin
        count_q <= count_q + COUNT_WIDTH'(1);
        px_q    <= nx_q;
        py_q    <= ny_q;
        pz_q    <= nz_lift;
        pvz_q   <= nvz_q;
        sx_q    <= nx_q;
        sy_q    <= ny_q;
        sz_q    <= nz_lift;
      end
    end
  end

  // operand select for the shared multiplier
  always_comb begin
    mul_b = $signed({1'b0, dt_q});
    unique case (cmd_i.op)
      OP_X:    mul_a = ivx_q;
      OP_Y:    mul_a = ivy_q;
      OP_Z:    mul_a = pvz_q;
      OP_G:    mul_a = GRAV_Q;
      OP_B: begin
        mul_a = nvz_q;
        mul_b = BOUNCE_Q;
      end
      default: mul_a = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s1_op_q  <= OP_X;
      s2_op_q  <= OP_X;
    end else begin
      s1_vld_q <= cmd_i.issue;
      s2_vld_q <= s1_vld_q;
      s1_op_q  <= cmd_i.op;
      s2_op_q  <= s1_op_q;
    end
  end

  // stage 1: product, stage 2: round and saturate
  always_ff @(posedge clk_i) begin
    prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
    rnd_q  <= round_sat(prod_q);
  end

  // stage 3: accumulate into the step result
  always_ff @(posedge clk_i) begin
    if (s2_vld_q) begin
      unique case (s2_op_q)
        OP_X:    nx_q  <= sat_sum((Q_W+1)'(px_q) + (Q_W+1)'(rnd_q));
        OP_Y:    ny_q  <= sat_sum((Q_W+1)'(py_q) + (Q_W+1)'(rnd_q));
        OP_Z:    nz_q  <= sat_sum((Q_W+1)'(pz_q) + (Q_W+1)'(rnd_q));
        OP_G:    nvz_q <= sat_sum((Q_W+1)'(pvz_q) + (Q_W+1)'(rnd_q));
        OP_B:    nvz_q <= sat_sum(-((Q_W+1)'(rnd_q)));
        default: nx_q  <= nx_q;
      endcase
    end
  end

  // output register
  assign out_free = !out_vld_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      pos_x_o      <= sx_q;
      pos_y_o      <= sy_q;
      pos_z_o      <= sz_q;
      vel_z_o      <= pvz_q;
      is_running_o <= run_q;
      steps_done_o <= count_q;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign sts_o.running  = run_q;
  assign sts_o.count_ge = (count_q >= limit_q);
  assign sts_o.z_neg    = nz_q[Q_W-1];
  assign sts_o.out_free = out_free;

endmodule

`default_nettype wire
